### rtl/set_assoc_cache_random_replace_top_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the set associative cache with random replacement
// Both macros expect clk and rst_n to be visible where they are used.
// -----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_RANDOM_REPLACE_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_RANDOM_REPLACE_TOP_DEFINES_SVH

// same-cycle implication
`define SACR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SACR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sacr_pkg.sv
// -----------------------------------------------------------------------------
// sacr_pkg
// Shared constants, types and helpers of the set associative cache.
// -----------------------------------------------------------------------------
package sacr_pkg;

    localparam int WAYS      = 4;
    localparam int SETS      = 256;
    localparam int ADDR_BITS = 20;
    localparam int TAG_W     = 20;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // result field widths
    localparam int WAY_OUT_W = 2;
    localparam int CNT_W     = 32;

    // config register widths
    localparam int OFFSET_W   = 5;
    localparam int SETB_W     = 4;
    localparam int WAYB_W     = 2;
    localparam int LFSR_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd2;
    localparam logic [SETB_W-1:0]   SETB_RESET   = 4'd4;
    localparam logic [WAYB_W-1:0]   WAYB_RESET   = 2'd0;
    localparam logic [LFSR_W-1:0]   LFSR_RESET   = 16'h0001;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;

    // front-to-back queue
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_SET_BITS    = 2'd1,
        CFG_WAY_BITS    = 2'd2,
        CFG_LFSR_SEED   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_bits;
        logic [SETB_W-1:0]   set_bits;
        logic [WAYB_W-1:0]   way_bits;
    } geom_t;

    typedef struct packed {
        logic              load;
        logic [LFSR_W-1:0] value;
    } seed_t;

    typedef struct packed {
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
    } req_t;

    typedef struct packed {
        logic             vld;
        logic [TAG_W-1:0] tag;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    // Galois step, right shift
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] nv;
        nv = v >> 1;
        if (v[0])
        begin
            nv = nv ^ LFSR_TAPS;
        end
        return nv;
    endfunction

endpackage

### rtl/set_assoc_cache_random_replace_top.sv
// -----------------------------------------------------------------------------
// set_assoc_cache_random_replace_top
// Set associative cache tag model with random (LFSR) replacement.
//
//   channel  dir  handshake           word
//   -------  ---  ------------------  ----------------------------------------
//   in       in   in_valid/in_stall   address
//   out      out  out_valid/out_stall hit, way_used, evicted_valid,
//                                     hit_count, miss_count
//   cfg      in   cfg_we              cfg_index, cfg_wdata (no read-back)
//
// Front takes one address per cycle into a 2-entry queue while in_stall is low.
// Back handles one word at a time: tag RAM read, then compare and, on a miss,
// fill write on the same RAM row; it takes no new word until that is done.
// After reset a clearing pass walks the 256 tag RAM rows;
// in_stall stays high meanwhile, config writes are still taken.
// out_stall holds the result register; back then waits with the next word.
// -----------------------------------------------------------------------------
module set_assoc_cache_random_replace_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sacr_pkg::ADDR_BITS-1:0]  address,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [sacr_pkg::WAY_OUT_W-1:0]  way_used,
    output logic                            evicted_valid,
    output logic [sacr_pkg::CNT_W-1:0]      hit_count,
    output logic [sacr_pkg::CNT_W-1:0]      miss_count,
    // configuration
    input  logic                            cfg_we,
    input  logic [sacr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sacr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // geometry registers live here; front uses all of them, back only way_bits
    sacr_pkg::geom_t geom_reg, geom_next;
    sacr_pkg::seed_t seed;

    sacr_pkg::req_t  req;
    logic            req_valid;
    logic            req_pop;
    logic            clearing;

    // config decode; a seed write goes straight to the back LFSR
    always_comb
    begin
        geom_next  = geom_reg;
        seed.load  = 1'b0;
        seed.value = cfg_wdata;
        if (cfg_we)
        begin
            unique case (sacr_pkg::cfg_idx_t'(cfg_index))
                sacr_pkg::CFG_OFFSET_BITS:
                begin
                    geom_next.offset_bits = cfg_wdata[sacr_pkg::OFFSET_W-1:0];
                end
                sacr_pkg::CFG_SET_BITS:
                begin
                    geom_next.set_bits = cfg_wdata[sacr_pkg::SETB_W-1:0];
                end
                sacr_pkg::CFG_WAY_BITS:
                begin
                    geom_next.way_bits = cfg_wdata[sacr_pkg::WAYB_W-1:0];
                end
                sacr_pkg::CFG_LFSR_SEED:
                begin
                    seed.load = 1'b1;
                end
                default:
                begin
                    seed.load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.offset_bits <= sacr_pkg::OFFSET_RESET;
            geom_reg.set_bits    <= sacr_pkg::SETB_RESET;
            geom_reg.way_bits    <= sacr_pkg::WAYB_RESET;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    // front: address split and request queue
    sacr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom_reg),
        .hold      (clearing),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .address   (address),
        .req       (req),
        .req_valid (req_valid),
        .req_pop   (req_pop)
    );

    // back: tag RAM, replacement, counters, result register
    sacr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .way_bits      (geom_reg.way_bits),
        .seed          (seed),
        .req           (req),
        .req_valid     (req_valid),
        .req_pop       (req_pop),
        .clearing      (clearing),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .way_used      (way_used),
        .evicted_valid (evicted_valid),
        .hit_count     (hit_count),
        .miss_count    (miss_count)
    );

endmodule

### rtl/sacr_ram.sv
// -----------------------------------------------------------------------------
// sacr_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sacr_front.sv
// -----------------------------------------------------------------------------
// sacr_front
// Splits an address into set index and tag and queues the request.
// -----------------------------------------------------------------------------
module sacr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sacr_pkg::geom_t                geom,
    input  logic                           hold,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sacr_pkg::ADDR_BITS-1:0] address,
    output sacr_pkg::req_t                 req,
    output logic                           req_valid,
    input  logic                           req_pop
);

    logic [sacr_pkg::ADDR_BITS-1:0] above;
    logic [sacr_pkg::ADDR_BITS-1:0] tag_full;
    logic [sacr_pkg::OFFSET_W:0]    tshift;
    logic [sacr_pkg::SET_W-1:0]     set_mask;
    sacr_pkg::req_t                 cls;

    sacr_pkg::req_t              q_reg [sacr_pkg::QDEPTH];
    logic [sacr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sacr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sacr_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        push;

    // classification
    always_comb
    begin
        above = address >> geom.offset_bits;
        for (int i = 0; i < sacr_pkg::SET_W; i++)
        begin
            set_mask[i] = (i < int'(geom.set_bits));
        end
        tshift      = {1'b0, geom.offset_bits} + (sacr_pkg::OFFSET_W + 1)'(geom.set_bits);
        tag_full    = address >> tshift;
        cls.set_idx = sacr_pkg::SET_W'(above) & set_mask;
        cls.tag     = sacr_pkg::TAG_W'(tag_full);
    end

    // queue
    assign in_stall  = hold || (cnt_reg == sacr_pkg::QCNT_W'(sacr_pkg::QDEPTH));
    assign push      = in_valid && !in_stall;
    assign req_valid = (cnt_reg != '0);
    assign req       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sacr_pkg::QPTR_W'(sacr_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (req_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sacr_pkg::QPTR_W'(sacr_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !req_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && req_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### rtl/sacr_back.sv
// -----------------------------------------------------------------------------
// sacr_back
// Tag store lookup, fill / random replacement, counters and result register.
// -----------------------------------------------------------------------------
module sacr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [sacr_pkg::WAYB_W-1:0]    way_bits,
    input  sacr_pkg::seed_t                seed,
    input  sacr_pkg::req_t                 req,
    input  logic                           req_valid,
    output logic                           req_pop,
    output logic                           clearing,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic [sacr_pkg::WAY_OUT_W-1:0] way_used,
    output logic                           evicted_valid,
    output logic [sacr_pkg::CNT_W-1:0]     hit_count,
    output logic [sacr_pkg::CNT_W-1:0]     miss_count
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t                       state_reg, state_next;
    logic [sacr_pkg::SET_W-1:0]   clr_reg, clr_next;
    sacr_pkg::req_t               cur_reg, cur_next;
    logic [sacr_pkg::LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic [sacr_pkg::CNT_W-1:0]   hit_tot_reg, hit_tot_next;
    logic [sacr_pkg::CNT_W-1:0]   miss_tot_reg, miss_tot_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_hit_reg, out_hit_next;
    logic [sacr_pkg::WAY_W-1:0]   out_way_reg, out_way_next;
    logic                         out_evict_reg, out_evict_next;
    logic [sacr_pkg::CNT_W-1:0]   out_hcnt_reg, out_hcnt_next;
    logic [sacr_pkg::CNT_W-1:0]   out_mcnt_reg, out_mcnt_next;

    // RAM port
    logic                         ram_we;
    logic [sacr_pkg::SET_W-1:0]   ram_waddr;
    sacr_pkg::row_t               ram_wdata;
    logic                         ram_re;
    logic [sacr_pkg::SET_W-1:0]   ram_raddr;
    sacr_pkg::row_t               row;

    // lookup
    logic [sacr_pkg::WAYS-1:0]    in_use;
    logic [sacr_pkg::WAY_W-1:0]   rand_mask;
    logic                         hit_any;
    logic [sacr_pkg::WAY_W-1:0]   hit_way;
    logic                         free_any;
    logic [sacr_pkg::WAY_W-1:0]   free_way;
    logic [sacr_pkg::WAY_W-1:0]   rand_way;
    logic [sacr_pkg::WAY_W-1:0]   sel_way;
    sacr_pkg::row_t               new_row;

    sacr_ram #(
        .WIDTH (sacr_pkg::ROW_W),
        .DEPTH (sacr_pkg::SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (row)
    );

    // ways in use: 1 << way_bits, saturated at WAYS
    always_comb
    begin
        for (int w = 0; w < sacr_pkg::WAYS; w++)
        begin
            in_use[w] = (w < (1 << way_bits));
        end
        for (int i = 0; i < sacr_pkg::WAY_W; i++)
        begin
            rand_mask[i] = (i < int'(way_bits));
        end
    end

    // lowest matching way and lowest free way
    always_comb
    begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = sacr_pkg::WAYS - 1; w >= 0; w--)
        begin
            if (in_use[w] && row[w].vld && (row[w].tag == cur_reg.tag))
            begin
                hit_any = 1'b1;
                hit_way = sacr_pkg::WAY_W'(w);
            end
            if (in_use[w] && !row[w].vld)
            begin
                free_any = 1'b1;
                free_way = sacr_pkg::WAY_W'(w);
            end
        end
        rand_way = sacr_pkg::WAY_W'(lfsr_reg) & rand_mask;
        if (hit_any)
        begin
            sel_way = hit_way;
        end
        else if (free_any)
        begin
            sel_way = free_way;
        end
        else
        begin
            sel_way = rand_way;
        end
        new_row              = row;
        new_row[sel_way].vld = 1'b1;
        new_row[sel_way].tag = cur_reg.tag;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        lfsr_next      = lfsr_reg;
        hit_tot_next   = hit_tot_reg;
        miss_tot_next  = miss_tot_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_way_next   = out_way_reg;
        out_evict_next = out_evict_reg;
        out_hcnt_next  = out_hcnt_reg;
        out_mcnt_next  = out_mcnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg.set_idx;
        ram_wdata      = new_row;
        ram_re         = 1'b0;
        ram_raddr      = req.set_idx;
        req_pop        = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == sacr_pkg::SET_W'(sacr_pkg::SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (out_valid_reg && !out_stall)
                begin
                    out_valid_next = 1'b0;
                end
                // start only when the result slot is free by the eval cycle
                if (req_valid && (!out_valid_reg || !out_stall))
                begin
                    ram_re     = 1'b1;
                    req_pop    = 1'b1;
                    cur_next   = req;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                ram_we         = !hit_any;
                out_valid_next = 1'b1;
                out_hit_next   = hit_any;
                out_way_next   = sel_way;
                out_evict_next = !hit_any && !free_any;
                if (hit_any)
                begin
                    hit_tot_next = hit_tot_reg + 1'b1;
                end
                else
                begin
                    miss_tot_next = miss_tot_reg + 1'b1;
                end
                if (!hit_any && !free_any)
                begin
                    lfsr_next = sacr_pkg::lfsr_step(lfsr_reg);
                end
                out_hcnt_next = hit_tot_next;
                out_mcnt_next = miss_tot_next;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // seed write, a zero seed loads one
        if (seed.load)
        begin
            lfsr_next = (seed.value == '0) ? sacr_pkg::LFSR_RESET : seed.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cur_reg       <= '0;
            lfsr_reg      <= sacr_pkg::LFSR_RESET;
            hit_tot_reg   <= '0;
            miss_tot_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_way_reg   <= '0;
            out_evict_reg <= 1'b0;
            out_hcnt_reg  <= '0;
            out_mcnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            lfsr_reg      <= lfsr_next;
            hit_tot_reg   <= hit_tot_next;
            miss_tot_reg  <= miss_tot_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_way_reg   <= out_way_next;
            out_evict_reg <= out_evict_next;
            out_hcnt_reg  <= out_hcnt_next;
            out_mcnt_reg  <= out_mcnt_next;
        end
    end

    assign clearing      = (state_reg == ST_CLEAR);
    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign way_used      = sacr_pkg::WAY_OUT_W'(out_way_reg);
    assign evicted_valid = out_evict_reg;
    assign hit_count     = out_hcnt_reg;
    assign miss_count    = out_mcnt_reg;

endmodule

### rtl/sacr_checker.sv
// -----------------------------------------------------------------------------
// sacr_checker
// Port-level checks of the cache top, attached by bind.
// -----------------------------------------------------------------------------
`include "set_assoc_cache_random_replace_top_defines.svh"

module sacr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            hit,
    input logic [sacr_pkg::WAY_OUT_W-1:0]  way_used,
    input logic                            evicted_valid,
    input logic [sacr_pkg::CNT_W-1:0]      hit_count,
    input logic [sacr_pkg::CNT_W-1:0]      miss_count
);

    logic                         in_acc;
    logic                         out_acc;
    logic [2:0]                   pend_reg;
    logic [sacr_pkg::CNT_W-1:0]   prev_hit_reg;
    logic [sacr_pkg::CNT_W-1:0]   prev_miss_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // words taken but not yet delivered, plus last delivered totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            prev_hit_reg  <= '0;
            prev_miss_reg <= '0;
        end
        else
        begin
            if (in_acc && !out_acc)
            begin
                pend_reg <= pend_reg + 1'b1;
            end
            else if (!in_acc && out_acc)
            begin
                pend_reg <= pend_reg - 1'b1;
            end
            if (out_acc)
            begin
                prev_hit_reg  <= hit_count;
                prev_miss_reg <= miss_count;
            end
        end
    end

    `SACR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(hit) && $stable(way_used) && $stable(hit_count),
        "result changed while stalled")

    `SACR_ASSERT_NOW(a_no_orphan, out_acc, pend_reg != '0,
        "result without an accepted address")

    `SACR_ASSERT_NOW(a_hit_count, out_acc && hit,
        (hit_count == prev_hit_reg + 1'b1) && (miss_count == prev_miss_reg),
        "hit totals out of step")

    `SACR_ASSERT_NOW(a_miss_count, out_acc && !hit,
        (miss_count == prev_miss_reg + 1'b1) && (hit_count == prev_hit_reg),
        "miss totals out of step")

    `SACR_ASSERT_NOW(a_evict_miss, out_valid && evicted_valid, !hit,
        "eviction reported on a hit")

endmodule

bind set_assoc_cache_random_replace_top sacr_checker u_sacr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .way_used      (way_used),
    .evicted_valid (evicted_valid),
    .hit_count     (hit_count),
    .miss_count    (miss_count)
);
